FILE: src/bse_pkg.sv
package bse_pkg;

  // Fixed field widths
  localparam int ACTION_W   = 3;
  localparam int SET_W      = 2;
  localparam int ITEM_W     = 10;
  localparam int UNIVERSE_W = 11;
  localparam int COUNT_W    = 11;

  // Store word geometry (word width is fixed; item bit index is item[5:0])
  localparam int WORD_BITS = 64;
  localparam int BIT_IDX_W = 6;
  localparam int POP_W     = 7;
  localparam int ACC_W     = 12;

  localparam logic [UNIVERSE_W-1:0] UNIVERSE_RESET = 11'd1024;
  localparam logic [COUNT_W-1:0]    COUNT_MAX      = 11'd2047;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD       = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_LOOKUP    = 3'd2,
    ACT_COUNT     = 3'd3,
    ACT_UNION     = 3'd4,
    ACT_INTERSECT = 3'd5
  } action_e;

  // What the accepted beat needs from the controller
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_BIT,
    KIND_WALK
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIT_RD,
    ST_BIT_WR,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SET_W-1:0]    set_id;
    logic [ITEM_W-1:0]   item;
    logic [SET_W-1:0]    src_a;
    logic [SET_W-1:0]    src_b;
  } in_beat_t;

  typedef struct packed {
    logic               member;
    logic [COUNT_W-1:0] count;
    logic               error;
  } out_beat_t;

  typedef struct packed {
    logic clr_en;
    logic accept;
    logic bit_rd;
    logic bit_wr;
    logic walk_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  clr_last;
    kind_e kind;
    logic  walk_done;
  } ctrl_sts_t;

  // Population count of one store word as a six-level adder tree
  function automatic logic [POP_W-1:0] popcount64(logic [WORD_BITS-1:0] w);
    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];
    for (int i = 0; i < 32; i++) l1[i] = 2'(w[2*i]) + 2'(w[2*i+1]);
    for (int i = 0; i < 16; i++) l2[i] = 3'(l1[2*i]) + 3'(l1[2*i+1]);
    for (int i = 0; i < 8; i++)  l3[i] = 4'(l2[2*i]) + 4'(l2[2*i+1]);
    for (int i = 0; i < 4; i++)  l4[i] = 5'(l3[2*i]) + 5'(l3[2*i+1]);
    for (int i = 0; i < 2; i++)  l5[i] = 6'(l4[2*i]) + 6'(l4[2*i+1]);
    return POP_W'(l5[0]) + POP_W'(l5[1]);
  endfunction

endpackage

FILE: src/bitmap_set_engine.sv
// Bit-vector set engine: NUM_SETS sets of up to UNIVERSE_MAX items each, kept as 64-bit
// words in a store with two read ports and one write port. One beat in gives one beat
// out, and the block works on one beat at a time. Add, remove and lookup read the word,
// add and remove then modify and write it, and the result is loaded; count, union and
// intersect walk one word per cycle over W = ceil(min(universe, UNIVERSE_MAX) / 64)
// words and then load the result; a beat that does nothing (bad set number, unused
// action, item out of range) goes straight to loading its result. The word walk is
// bounded by the single write port of the store. A result waits in an output register,
// and a new beat may be accepted while it sits there. After reset a clearing pass
// zeroes the store, one word per cycle, over its NUM_SETS * ceil(UNIVERSE_MAX / 64)
// words (64 with default parameters); the input is stalled during that pass while
// universe register writes are still taken.
module bitmap_set_engine #(
  parameter int NUM_SETS     = 4,
  parameter int UNIVERSE_MAX = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bse_pkg::UNIVERSE_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bse_pkg::in_beat_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bse_pkg::out_beat_t             out_data_o
);
  import bse_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bse_datapath #(
    .NUM_SETS     (NUM_SETS),
    .UNIVERSE_MAX (UNIVERSE_MAX)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // One beat at a time: an accepted beat stalls the input on the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a beat is in flight");

  // No beat is taken while the store is being cleared
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_en |-> in_stall_o)
    else $error("input open during clearing pass");

  // Store operations are mutually exclusive
  a_store_ops_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.clr_en, cmd.bit_rd, cmd.bit_wr, cmd.walk_en, cmd.out_load}))
    else $error("overlapping store commands");

  // A result appears only after the result register was loaded
  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.out_load))
    else $error("output valid without a result load");
`endif

endmodule

FILE: src/bse_ctrl.sv
module bse_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  bse_pkg::ctrl_sts_t sts_i,
  output bse_pkg::ctrl_cmd_t cmd_o
);
  import bse_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.kind)
            KIND_BIT:  state_d = ST_BIT_RD;
            KIND_WALK: state_d = ST_WALK;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_BIT_RD: state_d = ST_BIT_WR;
      ST_BIT_WR: state_d = ST_DONE;
      ST_WALK: begin
        if (sts_i.walk_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_CLEAR:  cmd_o.clr_en   = 1'b1;
      ST_IDLE:   cmd_o.accept   = in_valid_i;
      ST_BIT_RD: cmd_o.bit_rd   = 1'b1;
      ST_BIT_WR: cmd_o.bit_wr   = 1'b1;
      ST_WALK:   cmd_o.walk_en  = 1'b1;
      ST_DONE:   cmd_o.out_load = out_free;
      default:   cmd_o = '0;
    endcase
  end

  // Output beat valid: set on load, dropped when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)                   out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: src/bse_datapath.sv
module bse_datapath #(
  parameter int NUM_SETS     = 4,
  parameter int UNIVERSE_MAX = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bse_pkg::UNIVERSE_W-1:0]     cfg_wdata_i,
  input  bse_pkg::in_beat_t                  in_data_i,
  input  bse_pkg::ctrl_cmd_t                 cmd_i,
  output bse_pkg::ctrl_sts_t                 sts_o,
  output bse_pkg::out_beat_t                 out_data_o
);
  import bse_pkg::*;

  localparam int WPS       = (UNIVERSE_MAX + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH     = NUM_SETS * WPS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WIW       = (WPS > 1) ? $clog2(WPS) : 1;
  localparam int UNI_CAP   = (UNIVERSE_MAX < 2047) ? UNIVERSE_MAX : 2047;
  localparam int MAX_WALK  = (UNI_CAP + WORD_BITS - 1) / WORD_BITS;
  localparam int WCNT_W    = $clog2(MAX_WALK + 1);

  // Store word address: set base plus word within the set
  function automatic logic [ADDR_W-1:0] word_addr(logic [SET_W-1:0] set,
                                                  logic [WIW-1:0] word);
    return ADDR_W'(32'(set) * WPS + 32'(word));
  endfunction

  logic [WORD_BITS-1:0]  mem_q [DEPTH];
  logic [WORD_BITS-1:0]  rd_a_q, rd_b_q;
  logic [UNIVERSE_W-1:0] universe_q;
  logic [ADDR_W-1:0]     clr_addr_q;
  in_beat_t              op_q;
  logic                  err_q, member_q;
  logic [ACC_W-1:0]      acc_q;
  logic [WCNT_W-1:0]     walk_cnt_q;
  logic                  pend_q;
  logic [WIW-1:0]        widx_q;

  logic [UNIVERSE_W-1:0] uni;
  logic [WCNT_W-1:0]     words;
  logic                  issue;
  action_e               in_act, op_act;
  kind_e                 in_kind;
  logic                  set_ok, srcs_ok, item_err;
  logic [WIW-1:0]        bit_word, walk_word;
  logic [BIT_IDX_W-1:0]  bit_idx;
  logic [WORD_BITS-1:0]  bit_mask;
  logic                  we;
  logic [ADDR_W-1:0]     wa, ra_a, ra_b;
  logic [WORD_BITS-1:0]  wd;

  // Universe in use and the words that cover it
  assign uni   = (UNIVERSE_MAX < 32'(universe_q)) ? UNIVERSE_W'(UNIVERSE_MAX) : universe_q;
  assign words = WCNT_W'((13'(uni) + 13'(WORD_BITS - 1)) >> BIT_IDX_W);

  // Decode of the incoming beat
  assign in_act   = action_e'(in_data_i.action);
  assign set_ok   = 32'(in_data_i.set_id) < NUM_SETS;
  assign srcs_ok  = (32'(in_data_i.src_a) < NUM_SETS) && (32'(in_data_i.src_b) < NUM_SETS);
  assign item_err = 11'(in_data_i.item) >= uni;

  always_comb begin
    in_kind = KIND_NONE;
    case (in_act)
      ACT_ADD, ACT_REMOVE, ACT_LOOKUP: begin
        if (set_ok && !item_err) in_kind = KIND_BIT;
      end
      ACT_COUNT: begin
        if (set_ok) in_kind = KIND_WALK;
      end
      ACT_UNION, ACT_INTERSECT: begin
        if (set_ok && srcs_ok) in_kind = KIND_WALK;
      end
      default: in_kind = KIND_NONE;
    endcase
  end

  assign sts_o.kind      = in_kind;
  assign sts_o.clr_last  = (clr_addr_q == ADDR_W'(DEPTH - 1));
  assign sts_o.walk_done = (walk_cnt_q == words) && !pend_q;

  // Single-bit access fields
  assign op_act    = action_e'(op_q.action);
  assign bit_word  = WIW'(op_q.item[ITEM_W-1:BIT_IDX_W]);
  assign bit_idx   = op_q.item[BIT_IDX_W-1:0];
  assign bit_mask  = WORD_BITS'(1) << bit_idx;
  assign walk_word = WIW'(walk_cnt_q);
  assign issue     = cmd_i.walk_en && (walk_cnt_q != words);

  // Read addresses: port A serves bit ops, count and first source
  always_comb begin
    ra_a = word_addr(op_q.set_id, bit_word);
    if (cmd_i.walk_en) begin
      ra_a = word_addr((op_act == ACT_COUNT) ? op_q.set_id : op_q.src_a, walk_word);
    end
    ra_b = word_addr(op_q.src_b, walk_word);
  end

  // Write port: clearing pass, bit update or set-wise merge
  always_comb begin
    we = 1'b0;
    wa = word_addr(op_q.set_id, widx_q);
    wd = (op_act == ACT_UNION) ? (rd_a_q | rd_b_q) : (rd_a_q & rd_b_q);
    if (cmd_i.clr_en) begin
      we = 1'b1;
      wa = clr_addr_q;
      wd = '0;
    end else if (cmd_i.bit_wr) begin
      we = (op_act == ACT_ADD) || (op_act == ACT_REMOVE);
      wa = word_addr(op_q.set_id, bit_word);
      wd = (op_act == ACT_ADD) ? (rd_a_q | bit_mask) : (rd_a_q & ~bit_mask);
    end else if (pend_q) begin
      we = (op_act == ACT_UNION) || (op_act == ACT_INTERSECT);
    end
  end

  // Word store, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_a_q <= mem_q[ra_a];
    rd_b_q <= mem_q[ra_b];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      universe_q <= UNIVERSE_RESET;
      clr_addr_q <= '0;
      walk_cnt_q <= '0;
      pend_q     <= 1'b0;
    end else begin
      if (cfg_we_i)     universe_q <= cfg_wdata_i;
      if (cmd_i.clr_en) clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (cmd_i.accept) walk_cnt_q <= '0;
      else if (issue)   walk_cnt_q <= walk_cnt_q + WCNT_W'(1);
      pend_q <= issue;
    end
  end

  // Operation payload and result accumulation
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= in_data_i;
      err_q    <= set_ok && item_err &&
                  ((in_act == ACT_ADD) || (in_act == ACT_REMOVE) || (in_act == ACT_LOOKUP));
      member_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      if (cmd_i.bit_wr && (op_act == ACT_LOOKUP)) member_q <= rd_a_q[bit_idx];
      if (pend_q && (op_act == ACT_COUNT)) acc_q <= acc_q + ACC_W'(popcount64(rd_a_q));
    end
    widx_q <= walk_word;
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o.member <= member_q;
      out_data_o.count  <= (acc_q > ACC_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(acc_q);
      out_data_o.error  <= err_q;
    end
  end

endmodule
